// ===== hw/rtl/mips_overlay_relocator_assert.svh =====
// ----------------------------------------------------------------------------
// mips_overlay_relocator_assert.svh
// assertion macros used by the relocator rtl
// ----------------------------------------------------------------------------
`ifndef MIPS_OVERLAY_RELOCATOR_ASSERT_SVH
`define MIPS_OVERLAY_RELOCATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MOR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("relocator check failed");

// next-cycle implication, checked outside reset
`define MOR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("relocator check failed");

`endif

// ===== hw/rtl/mor_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mor_pkg
// constants and types for the mips overlay relocator
// ----------------------------------------------------------------------------
package mor_pkg;

    // register file of remembered lui words, one entry per mips register
    localparam int REG_COUNT = 32;
    localparam int REG_IDX_W = $clog2(REG_COUNT);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_SIZE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_SIZE = 2'd3;

    // section selectors
    localparam logic [1:0] SEC_NULL   = 2'd0;
    localparam logic [1:0] SEC_TEXT   = 2'd1;
    localparam logic [1:0] SEC_DATA   = 2'd2;
    localparam logic [1:0] SEC_RODATA = 2'd3;

    // elf mips relocation types
    localparam logic [5:0] RELOC_ABS32  = 6'd2;
    localparam logic [5:0] RELOC_JUMP26 = 6'd4;
    localparam logic [5:0] RELOC_HI16   = 6'd5;
    localparam logic [5:0] RELOC_LO16   = 6'd6;

    // kseg0 segment bits for jump targets
    localparam logic [3:0] KSEG0_TOP = 4'h8;

    // one write beat on the result side
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] data;
        logic        last;
    } t_beat;

endpackage

// ===== hw/rtl/mips_overlay_relocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_overlay_relocator
// applies one mips elf relocation per input beat and emits patched words
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit up)                tlast
//  s         in         reloc_word, target_word           table_last
//  m         out        write_addr, write_data            last
//  cfg       in         wdata: load/link base, sizes      -
//
//  an accepted beat is held in the input register, worked out and placed
//  in the result register when it advances; a lo16 item that passes its
//  check gives two write beats through the one result port, so a later
//  item that writes waits for the second beat; other types go at one item
//  per cycle while the output is not stalled; reset clears the valid flags
//  and the configuration; the lui entries are not cleared and need no pass
//  while a result waits, the input side takes a beat only when the input
//  register is empty or holds an item that writes nothing
// ----------------------------------------------------------------------------
`include "mips_overlay_relocator_assert.svh"

module mips_overlay_relocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input stream
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [63:0]                  i_s_tdata,   // reloc_word, target_word
    input  logic                         i_s_tlast,   // table_last
    // output stream
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [63:0]                  o_m_tdata,   // write_addr, write_data
    output logic                         o_m_tlast,   // last
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [mor_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                  i_cfg_wdata
);

    // configuration and derived bases
    logic [31:0] r_load_base;
    logic [31:0] r_link_base;
    logic [23:0] r_text_size;
    logic [23:0] r_data_size;
    logic [31:0] r_data_base;
    logic [31:0] r_rodata_base;
    logic [31:0] r_delta;

    // input register
    logic        r_in_valid;
    logic [31:0] r_in_rel;
    logic [31:0] r_in_word;

    // lui register file
    logic [31:0] r_hi_addr [mor_pkg::REG_COUNT];
    logic [31:0] r_hi_orig [mor_pkg::REG_COUNT];
    logic [31:0] r_hi_now  [mor_pkg::REG_COUNT];

    // result register and second beat
    logic                r_out_valid;
    mor_pkg::t_beat      r_out;
    logic                r_pend_valid;
    mor_pkg::t_beat      r_pend;

    // working signals
    logic [5:0]                    w_type;
    logic [31:0]                   w_base;
    logic [31:0]                   w_addr;
    logic [mor_pkg::REG_IDX_W-1:0] w_rs;
    logic [mor_pkg::REG_IDX_W-1:0] w_rt;
    logic [31:0]                   w_lo_ext;
    logic [31:0]                   w_e_addr;
    logic [31:0]                   w_e_orig;
    logic [31:0]                   w_e_now;
    logic [31:0]                   w_chk;
    logic [31:0]                   w_r;
    logic [15:0]                   w_hi16;
    logic [31:0]                   w_jtgt;
    logic [31:0]                   w_lui;
    logic [1:0]                    w_n;
    logic                          w_hi_wr;
    logic                          w_now_wr;
    mor_pkg::t_beat                w_b0;
    mor_pkg::t_beat                w_b1;
    logic                          w_out_free;
    logic                          w_adv;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_base <= '0;
            r_link_base <= '0;
            r_text_size <= '0;
            r_data_size <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mor_pkg::CFG_LOAD_BASE: r_load_base <= i_cfg_wdata;
                mor_pkg::CFG_LINK_BASE: r_link_base <= i_cfg_wdata;
                mor_pkg::CFG_TEXT_SIZE: r_text_size <= i_cfg_wdata[23:0];
                mor_pkg::CFG_DATA_SIZE: r_data_size <= i_cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // section bases and rebase offset, registered from the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_base   <= '0;
            r_rodata_base <= '0;
            r_delta       <= '0;
        end else begin
            r_data_base   <= r_load_base + {8'd0, r_text_size};
            r_rodata_base <= r_load_base + {8'd0, r_text_size} + {8'd0, r_data_size};
            r_delta       <= r_load_base - r_link_base;
        end
    end

    // input handshake
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_rel  <= i_s_tdata[31:0];
            r_in_word <= i_s_tdata[63:32];
        end
    end

    // target address from section base
    assign w_type = r_in_rel[29:24];

    always_comb begin
        case (r_in_rel[31:30])
            mor_pkg::SEC_TEXT:   w_base = r_load_base;
            mor_pkg::SEC_DATA:   w_base = r_data_base;
            mor_pkg::SEC_RODATA: w_base = r_rodata_base;
            default:             w_base = '0;
        endcase
    end

    assign w_addr = w_base + {8'd0, r_in_rel[23:0]};

    // register file lookup for the lo16 pairing
    assign w_rs     = r_in_word[25:21];
    assign w_rt     = r_in_word[20:16];
    assign w_e_addr = r_hi_addr[w_rs];
    assign w_e_orig = r_hi_orig[w_rs];
    assign w_e_now  = r_hi_now[w_rs];
    assign w_lo_ext = {{16{r_in_word[15]}}, r_in_word[15:0]};

    // lo16 rebase and lui carry
    assign w_chk  = {w_e_now[15:0], 16'd0} + w_lo_ext;
    assign w_r    = {w_e_orig[15:0], 16'd0} + w_lo_ext + r_delta;
    assign w_hi16 = w_r[31:16] + {15'd0, w_r[15]};
    assign w_lui  = {w_e_now[31:16], w_hi16};

    // jump target placed in kseg0 and rebased
    assign w_jtgt = {mor_pkg::KSEG0_TOP, r_in_word[25:0], 2'b00} + r_delta;

    // per-type result selection
    always_comb begin
        w_n      = 2'd0;
        w_hi_wr  = 1'b0;
        w_now_wr = 1'b0;
        w_b0     = '{addr: w_addr, data: r_in_word + r_delta, last: 1'b1};
        w_b1     = '{addr: w_addr, data: {r_in_word[31:16], w_r[15:0]}, last: 1'b1};
        case (w_type)
            mor_pkg::RELOC_ABS32: begin
                if (r_in_word[27:24] == 4'd0) begin
                    w_n = 2'd1;
                end
            end
            mor_pkg::RELOC_JUMP26: begin
                w_n       = 2'd1;
                w_b0.data = {r_in_word[31:26], w_jtgt[27:2]};
            end
            mor_pkg::RELOC_HI16: begin
                w_hi_wr = 1'b1;
            end
            mor_pkg::RELOC_LO16: begin
                if (w_chk[27:24] == 4'd0) begin
                    w_n      = 2'd2;
                    w_now_wr = 1'b1;
                    w_b0     = '{addr: w_e_addr, data: w_lui, last: 1'b0};
                end
            end
            default: ;
        endcase
    end

    // advance when the item writes nothing or the result side can take every beat of it
    assign w_out_free = !r_pend_valid && (!r_out_valid || i_m_tready);
    assign w_adv      = r_in_valid && ((w_n == 2'd0) || w_out_free);

    // register file update
    always_ff @(posedge i_clk) begin
        if (w_adv && w_hi_wr) begin
            r_hi_addr[w_rt] <= w_addr;
            r_hi_orig[w_rt] <= r_in_word;
            r_hi_now[w_rt]  <= r_in_word;
        end else if (w_adv && w_now_wr) begin
            r_hi_now[w_rs]  <= w_lui;
        end
    end

    // result register and second beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (w_adv && (w_n != 2'd0)) begin
            r_out_valid  <= 1'b1;
            r_pend_valid <= (w_n == 2'd2);
        end else if (r_out_valid && i_m_tready) begin
            r_out_valid  <= r_pend_valid;
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && (w_n != 2'd0)) begin
            r_out  <= w_b0;
            r_pend <= w_b1;
        end else if (r_out_valid && i_m_tready && r_pend_valid) begin
            r_out  <= r_pend;
        end
    end

    // output port
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.data, r_out.addr};
    assign o_m_tlast  = r_out.last;

    // checks
    `MOR_ASSERT_NOW(a_pend_behind_out, r_pend_valid, r_out_valid)
    `MOR_ASSERT_NOW(a_lui_beat_first, r_pend_valid, !r_out.last)
    `MOR_ASSERT_NEXT(a_second_beat_follows, r_out_valid && i_m_tready && r_pend_valid,
        r_out_valid && r_out.last && !r_pend_valid)
    `MOR_ASSERT_NEXT(a_stalled_item_held, r_in_valid && !w_adv,
        r_in_valid && $stable(r_in_rel) && $stable(r_in_word))

endmodule
